@@ rtl/w2e_pkg.sv @@
package w2e_pkg;

  // Frame geometry
  localparam int unsigned BufBytes   = 32;  // 24-byte MAC header plus 8 LLC/SNAP bytes
  localparam int unsigned WlanHdr    = 24;
  localparam int unsigned EthHdr     = 14;
  localparam int unsigned SnapLen    = 6;   // AA AA 03 00 00 00
  localparam int unsigned TypeHiIdx  = 30;  // SNAP ethertype bytes
  localparam int unsigned TypeLoIdx  = 31;
  localparam int unsigned MaxLastIdx = EthHdr + BufBytes - WlanHdr - 1;

  // Address field offsets in the 802.11 header
  localparam logic [4:0] Addr1Ofs = 5'd4;
  localparam logic [4:0] Addr2Ofs = 5'd10;
  localparam logic [4:0] Addr3Ofs = 5'd16;

  // Output queue sizing
  localparam int unsigned OutqDepth = 4;
  localparam int unsigned PtrW      = $clog2(OutqDepth);
  localparam int unsigned LvlW      = $clog2(OutqDepth + 1);

  // Distribution system direction bits (frame byte 1, bits 1:0)
  typedef enum logic [1:0] {
    DIR_NO_DS   = 2'd0,
    DIR_TO_DS   = 2'd1,
    DIR_FROM_DS = 2'd2,
    DIR_DS_DS   = 2'd3
  } dir_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [11:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       dropped;
  } out_item_t;

  // Expected LLC/SNAP byte at offset k past the MAC header
  function automatic logic [7:0] snap_pattern(input logic [2:0] k);
    logic [7:0] v;
    unique case (k)
      3'd0, 3'd1: v = 8'hAA;
      3'd2:       v = 8'h03;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/wifi_to_ethernet_header_translate_top.sv @@
// 802.11 data frame to Ethernet header translation, one byte per transaction.
// The first 32 bytes of each frame (MAC header plus a possible LLC/SNAP
// header) are held in a 32-byte header buffer and produce no output; once 32
// bytes are in, or the frame ends sooner, the block picks destination and
// source from the direction bits and emits a 14-byte Ethernet header, then any
// buffered payload, then forwards every later byte at one byte per cycle
// unless stalled. The header burst is read out of the buffer's single read
// port one byte per cycle while the queue has room, so input stalls for a
// 14- to 22-byte burst per translated frame (14 when SNAP is stripped, else
// 14 plus one per buffered byte from byte 24 on); dropped frames cause no
// burst stall. Frames under 24 bytes and DS-to-DS frames give a single
// result with dropped set. Each result passes the read stage, then the output
// queue; header bytes issue from the burst state set by the transaction that
// completes the header. A 4-entry output queue keeps input flowing while
// results wait; input stalls once the queue and the read stage would be full.
module wifi_to_ethernet_header_translate_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  w2e_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output w2e_pkg::out_item_t   out_item
);
  import w2e_pkg::*;

  logic             push;
  out_item_t        push_item;
  logic [LvlW-1:0]  q_level;

  // Frame parsing, header buffer and burst sequencer
  w2e_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_level   (q_level),
    .push      (push),
    .push_item (push_item)
  );

  // Output queue
  w2e_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .level     (q_level)
  );

endmodule

@@ rtl/w2e_ctrl.sv @@
module w2e_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  w2e_pkg::in_item_t           in_item,
  input  logic [w2e_pkg::LvlW-1:0]    q_level,
  output logic                        push,
  output w2e_pkg::out_item_t          push_item
);
  import w2e_pkg::*;

  typedef struct packed {
    logic       valid;
    logic       use_mem;
    logic [4:0] addr;
    logic [7:0] const_byte;
    logic       last;
    logic       drop;
  } op_t;

  // Header buffer
  logic [7:0] hdr_mem [BufBytes];

  // Frame state
  logic [4:0]  idx_r, idx_nxt;
  logic [11:0] len_r, len_nxt;
  logic        drop_pend_r, drop_pend_nxt;
  logic        pass_r, pass_nxt;
  dir_t        dir_r, dir_nxt;
  logic        snap_ok_r, snap_ok_nxt;

  // Header burst sequencer
  logic        burst_r, burst_nxt;
  logic [4:0]  bj_r, bj_nxt;
  logic [4:0]  bcnt_m1_r, bcnt_m1_nxt;
  logic [4:0]  dst_r, dst_nxt;
  logic [4:0]  src_r, src_nxt;
  logic        bsnap_r, bsnap_nxt;
  logic [15:0] type_r, type_nxt;
  logic        blast_r, blast_nxt;

  // Read stage
  logic        b_valid_r;
  logic        b_use_mem_r;
  logic        b_last_r;
  logic        b_drop_r;
  logic [7:0]  b_byte_r;
  logic [7:0]  mem_rd_r;

  op_t         op;
  op_t         bop;
  logic        room;
  logic        acc;
  logic        wr_en;
  logic        snap_now;
  logic [5:0]  n_cur;
  logic [15:0] type_calc;

  // Issue only when the queue can absorb this op plus the one in the read stage
  assign room     = ({1'b0, q_level} + {{LvlW{1'b0}}, b_valid_r}) < (LvlW + 1)'(OutqDepth);
  assign in_stall = burst_r | ~room;
  assign acc      = in_valid & ~in_stall;
  assign n_cur    = {1'b0, idx_r} + 6'd1;
  assign type_calc = (len_r >= 12'(WlanHdr)) ? {4'b0, len_r - 12'(WlanHdr)} : 16'd0;
  assign snap_now  = (n_cur == 6'(BufBytes)) && snap_ok_r;

  // Ethernet header byte for the current burst step
  always_comb begin
    bop            = '0;
    bop.valid      = 1'b1;
    bop.use_mem    = 1'b1;
    bop.last       = blast_r && (bj_r == bcnt_m1_r);
    priority if (bj_r < 5'd6) begin
      bop.addr = dst_r + bj_r;
    end else if (bj_r < 5'd12) begin
      bop.addr = src_r + (bj_r - 5'd6);
    end else if (bj_r == 5'd12) begin
      bop.use_mem    = bsnap_r;
      bop.addr       = 5'(TypeHiIdx);
      bop.const_byte = type_r[15:8];
    end else if (bj_r == 5'd13) begin
      bop.use_mem    = bsnap_r;
      bop.addr       = 5'(TypeLoIdx);
      bop.const_byte = type_r[7:0];
    end else begin
      // buffered payload following the MAC header
      bop.addr = bj_r + 5'(WlanHdr - EthHdr);
    end
  end

  // Frame control and op issue
  always_comb begin
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    drop_pend_nxt = drop_pend_r;
    pass_nxt      = pass_r;
    dir_nxt       = dir_r;
    snap_ok_nxt   = snap_ok_r;
    burst_nxt     = burst_r;
    bj_nxt        = bj_r;
    bcnt_m1_nxt   = bcnt_m1_r;
    dst_nxt       = dst_r;
    src_nxt       = src_r;
    bsnap_nxt     = bsnap_r;
    type_nxt      = type_r;
    blast_nxt     = blast_r;
    op            = '0;
    wr_en         = 1'b0;

    if (burst_r) begin
      if (room) begin
        op = bop;
        if (bj_r == bcnt_m1_r) begin
          burst_nxt = 1'b0;
          pass_nxt  = ~blast_r;
        end else begin
          bj_nxt = bj_r + 5'd1;
        end
      end
    end else if (acc) begin
      if (pass_r) begin
        op.valid      = 1'b1;
        op.const_byte = in_item.data_byte;
        op.last       = in_item.last_byte;
        if (in_item.last_byte) pass_nxt = 1'b0;
      end else if (drop_pend_r) begin
        if (in_item.last_byte) begin
          op.valid      = 1'b1;
          op.last       = 1'b1;
          op.drop       = 1'b1;
          drop_pend_nxt = 1'b0;
        end
      end else begin
        wr_en = 1'b1;
        if (idx_r == 5'd0) len_nxt = in_item.frame_length;
        if (idx_r == 5'd1) dir_nxt = dir_t'(in_item.data_byte[1:0]);
        // running LLC/SNAP match
        if (idx_r == 5'(WlanHdr)) begin
          snap_ok_nxt = in_item.data_byte == snap_pattern(3'd0);
        end else if (idx_r > 5'(WlanHdr) && idx_r < 5'(WlanHdr + SnapLen)) begin
          snap_ok_nxt = snap_ok_r &&
                        (in_item.data_byte == snap_pattern(3'(idx_r - 5'(WlanHdr))));
        end

        if (n_cur < 6'(BufBytes) && !in_item.last_byte) begin
          idx_nxt = idx_r + 5'd1;
        end else begin
          idx_nxt = 5'd0;
          if (n_cur < 6'(WlanHdr)) begin
            op.valid = 1'b1;
            op.last  = 1'b1;
            op.drop  = 1'b1;
          end else if (dir_r == DIR_DS_DS) begin
            if (in_item.last_byte) begin
              op.valid = 1'b1;
              op.last  = 1'b1;
              op.drop  = 1'b1;
            end else begin
              drop_pend_nxt = 1'b1;
            end
          end else begin
            burst_nxt   = 1'b1;
            bj_nxt      = 5'd0;
            blast_nxt   = in_item.last_byte;
            bsnap_nxt   = snap_now;
            type_nxt    = type_calc;
            dst_nxt     = (dir_r == DIR_TO_DS) ? Addr3Ofs : Addr1Ofs;
            src_nxt     = (dir_r == DIR_FROM_DS) ? Addr3Ofs : Addr2Ofs;
            bcnt_m1_nxt = snap_now ? 5'(EthHdr - 1)
                                   : 5'(n_cur - 6'(WlanHdr - EthHdr + 1));
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 5'd0;
      drop_pend_r <= 1'b0;
      pass_r      <= 1'b0;
      burst_r     <= 1'b0;
      b_valid_r   <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      drop_pend_r <= drop_pend_nxt;
      pass_r      <= pass_nxt;
      burst_r     <= burst_nxt;
      b_valid_r   <= op.valid;
    end
  end

  // Frame and burst payload
  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    dir_r       <= dir_nxt;
    snap_ok_r   <= snap_ok_nxt;
    bj_r        <= bj_nxt;
    bcnt_m1_r   <= bcnt_m1_nxt;
    dst_r       <= dst_nxt;
    src_r       <= src_nxt;
    bsnap_r     <= bsnap_nxt;
    type_r      <= type_nxt;
    blast_r     <= blast_nxt;
    b_use_mem_r <= op.use_mem;
    b_last_r    <= op.last;
    b_drop_r    <= op.drop;
    b_byte_r    <= op.const_byte;
  end

  // Header buffer write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) hdr_mem[idx_r] <= in_item.data_byte;
    if (op.valid && op.use_mem) mem_rd_r <= hdr_mem[op.addr];
  end

  assign push                = b_valid_r;
  assign push_item.out_byte  = b_use_mem_r ? mem_rd_r : b_byte_r;
  assign push_item.out_last  = b_last_r;
  assign push_item.dropped   = b_drop_r;

  // Checks
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pass_r && drop_pend_r))
    else $error("payload pass and drop swallow both active");

  a_burst_alone: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r |-> (!pass_r && !drop_pend_r))
    else $error("header burst overlaps another frame mode");

  a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r |-> (bcnt_m1_r >= 5'(EthHdr - 1) && bcnt_m1_r <= 5'(MaxLastIdx)
                 && bj_r <= bcnt_m1_r))
    else $error("header burst length out of range");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (burst_r && room && bj_r == bcnt_m1_r) |=> !burst_r)
    else $error("header burst did not end after its final byte");

endmodule

@@ rtl/w2e_outq.sv @@
module w2e_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  w2e_pkg::out_item_t          push_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output w2e_pkg::out_item_t          out_item,
  output logic [w2e_pkg::LvlW-1:0]    level
);
  import w2e_pkg::*;

  out_item_t            entry_r [OutqDepth];
  logic [PtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [LvlW-1:0]      level_r, level_nxt;
  logic                 pop;

  assign out_valid = level_r != '0;
  assign out_item  = entry_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;
  assign level     = level_r;

  // Pointer and fill level update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   level_nxt = level_r + LvlW'(1);
      2'b01:   level_nxt = level_r - LvlW'(1);
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && level_r == LvlW'(OutqDepth)))
    else $error("output queue overflow");

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LvlW'(OutqDepth))
    else $error("output queue level beyond depth");

  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (level_r == $past(level_r) + LvlW'(1)))
    else $error("output queue level did not track a push");

endmodule
